FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property checked at every rising clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `ASSERT_AT(lbl, clk, rst_n, !(cond), msg)

`else

`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

FILE: sv/cbd_pkg.sv
// ----------------------------------------------------------------------------
// cbd_pkg
// shared codes, byte constants and the hex digit decoder
// ----------------------------------------------------------------------------
package cbd_pkg;

  typedef enum logic [1:0] {
    StBusy  = 2'd0,
    StDone  = 2'd1,
    StBad   = 2'd2,
    StLarge = 2'd3
  } cbd_status_e;

  localparam logic [7:0] ChCr   = 8'h0d;
  localparam logic [7:0] ChLf   = 8'h0a;
  localparam logic [7:0] ChSemi = 8'h3b;

  // one hex digit is four bits of the size
  localparam int unsigned HexShift = 4;

  typedef struct packed {
    logic                ok;
    logic [HexShift-1:0] val;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] b);
    hex_t h;
    h.ok  = 1'b1;
    h.val = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.val = HexShift'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.val = HexShift'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.val = HexShift'(b - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

FILE: sv/chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// chunked_body_decoder
// byte-serial decoder for a chunked transfer body, one result per input byte
// result: registered, presented in the cycle after its input byte is accepted
// throughput: 1 byte per cycle while the result is not stalled, set by the single state update per byte
// reset: async active low, decoder at start of a size line, limit 1048576
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chunked_body_decoder #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // limit register
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,

  // byte input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic        s_axis_tuser,   // [0] start_of_body

  // decoded output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] data_byte, [9:8] decode_status,
                                      // [41:10] consumed_bytes, [47:42] zero
  output logic        m_axis_tuser    // [0] data_valid
);
  import cbd_pkg::*;

  // width of the no-wrap size check: covers both the count and the 32-bit limit
  localparam int unsigned SumW = (COUNT_BITS > 32) ? COUNT_BITS + 1 : 33;

  typedef enum logic [3:0] {
    PhSize,
    PhSizeLf,
    PhExt,
    PhExtCr,
    PhData,
    PhDataCr,
    PhDataLf,
    PhTrStart,
    PhTrStartCr,
    PhTrLine,
    PhTrLineCr
  } phase_e;

  // decoder state
  phase_e                phase_q, phase_d;
  logic [COUNT_BITS-1:0] acc_q, acc_d;
  logic                  seen_q, seen_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [COUNT_BITS-1:0] blen_q, blen_d;
  logic [31:0]           cnt_q, cnt_d;
  cbd_status_e           status_q, status_d;
  logic [31:0]           max_q;

  // result register
  logic                  out_valid_q;
  logic                  out_dv_q, out_dv_d;
  logic [7:0]            out_byte_q, out_byte_d;
  cbd_status_e           out_st_q;
  logic [31:0]           out_cnt_q;

  logic                  s_accept;
  logic                  m_accept;
  hex_t                  hex;
  logic                  line_done;
  logic [SumW-1:0]       size_sum;

  // a new byte is taken whenever the result register is empty or draining
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_accept      = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign hex           = hex_digit(s_axis_tdata);

  always_comb begin
    phase_d    = phase_q;
    acc_d      = acc_q;
    seen_d     = seen_q;
    rem_d      = rem_q;
    blen_d     = blen_q;
    cnt_d      = cnt_q;
    status_d   = status_q;
    out_dv_d   = 1'b0;
    out_byte_d = '0;
    line_done  = 1'b0;
    size_sum   = '0;

    // start of body wipes everything before this byte is looked at
    if (s_axis_tuser) begin
      phase_d  = PhSize;
      acc_d    = '0;
      seen_d   = 1'b0;
      rem_d    = '0;
      blen_d   = '0;
      cnt_d    = '0;
      status_d = StBusy;
    end

    // once a final status is set, bytes are dropped until the next start
    if (status_d == StBusy) begin
      if (cnt_d != '1) begin
        cnt_d = cnt_d + 32'd1;
      end
      unique case (phase_d)
        PhSize: begin
          if (hex.ok) begin
            // the next digit would push the size past the counter width
            if (acc_d[COUNT_BITS-1 -: HexShift] != '0) begin
              status_d = StBad;
            end else begin
              acc_d  = {acc_d[COUNT_BITS-HexShift-1:0], hex.val};
              seen_d = 1'b1;
            end
          end else if (s_axis_tdata == ChSemi) begin
            if (!seen_d) status_d = StBad;
            else         phase_d  = PhExt;
          end else if (s_axis_tdata == ChCr) begin
            phase_d = PhSizeLf;
          end else begin
            status_d = StBad;
          end
        end
        PhSizeLf: begin
          if (s_axis_tdata == ChLf) line_done = 1'b1;
          else                      status_d  = StBad;
        end
        PhExt: begin
          if (s_axis_tdata == ChCr) phase_d = PhExtCr;
        end
        PhExtCr: begin
          if (s_axis_tdata == ChLf)      line_done = 1'b1;
          else if (s_axis_tdata != ChCr) phase_d   = PhExt;
        end
        PhData: begin
          out_dv_d   = 1'b1;
          out_byte_d = s_axis_tdata;
          rem_d      = rem_d - COUNT_BITS'(1);
          blen_d     = blen_d + COUNT_BITS'(1);
          if (rem_d == '0) phase_d = PhDataCr;
        end
        PhDataCr: begin
          if (s_axis_tdata == ChCr) phase_d  = PhDataLf;
          else                      status_d = StBad;
        end
        PhDataLf: begin
          if (s_axis_tdata == ChLf) begin
            phase_d = PhSize;
            acc_d   = '0;
            seen_d  = 1'b0;
          end else begin
            status_d = StBad;
          end
        end
        PhTrStart: begin
          phase_d = (s_axis_tdata == ChCr) ? PhTrStartCr : PhTrLine;
        end
        PhTrStartCr: begin
          // empty line closes the body
          if (s_axis_tdata == ChLf) status_d = StDone;
          else phase_d = (s_axis_tdata == ChCr) ? PhTrLineCr : PhTrLine;
        end
        PhTrLine: begin
          if (s_axis_tdata == ChCr) phase_d = PhTrLineCr;
        end
        PhTrLineCr: begin
          if (s_axis_tdata == ChLf)      phase_d = PhTrStart;
          else if (s_axis_tdata != ChCr) phase_d = PhTrLine;
        end
        default: status_d = StBad;
      endcase

      // end of a size line: empty, last chunk, over the limit, or data
      if (line_done) begin
        size_sum = SumW'(blen_d) + SumW'(acc_d);
        if (!seen_d) begin
          status_d = StBad;
        end else if (acc_d == '0) begin
          phase_d = PhTrStart;
        end else if (size_sum > SumW'(max_q)) begin
          status_d = StLarge;
        end else begin
          rem_d   = acc_d;
          phase_d = PhData;
        end
      end
    end
  end

  // state, limit register and result handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhSize;
      acc_q       <= '0;
      seen_q      <= 1'b0;
      rem_q       <= '0;
      blen_q      <= '0;
      cnt_q       <= '0;
      status_q    <= StBusy;
      max_q       <= 32'd1048576;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (s_accept) begin
        phase_q     <= phase_d;
        acc_q       <= acc_d;
        seen_q      <= seen_d;
        rem_q       <= rem_d;
        blen_q      <= blen_d;
        cnt_q       <= cnt_d;
        status_q    <= status_d;
        out_valid_q <= 1'b1;
      end else if (m_accept) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted byte
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      out_dv_q   <= out_dv_d;
      out_byte_q <= out_byte_d;
      out_st_q   <= status_d;
      out_cnt_q  <= cnt_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_dv_q;
  assign m_axis_tdata  = {6'b0, out_cnt_q, out_st_q, out_byte_q};

  // a stalled result blocks the input side
  `ASSERT_AT(a_stall_blocks_input, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready, "input taken while result stalled")

  // data phase always has bytes left to pass
  `ASSERT_NEVER(a_data_rem_nonzero, clk_i, rst_ni, (phase_q == PhData) && (rem_q == '0), "data phase with zero bytes remaining")

  // payload bytes are only produced while decoding is in progress
  `ASSERT_AT(a_payload_busy, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[9:8] == StBusy), "payload byte with final status")

  // a final status sticks until the next start of body
  `ASSERT_AT(a_status_sticky, clk_i, rst_ni, (s_accept && !s_axis_tuser && status_q != StBusy) |=> (out_st_q == $past(status_q) && !out_dv_q), "final status not held")

endmodule

FILE: tb/chunked_body_decoder_test.sv
// ----------------------------------------------------------------------------
// chunked_body_decoder_test
// self-checking bench for the chunked body decoder: byte requests come from a
// queue that is filled with directed bodies and random well-formed, damaged
// and noisy bodies, every result is checked against a predictor of the
// decoder, and the limit register is moved between phases of varying idling
// ----------------------------------------------------------------------------
module chunked_body_decoder_test;
  import cbd_pkg::*;

  localparam int CountBits = 32;
  localparam int MaxCycles = 300000;

  // decoder position inside the body, kept by the predictor
  typedef enum logic [3:0] {
    PhSize, PhSizeLf, PhExt, PhExtCr, PhData, PhDataCr, PhDataLf,
    PhTrStart, PhTrStartCr, PhTrLine, PhTrLineCr
  } body_phase_e;

  typedef struct packed {
    logic       sob;
    logic [7:0] value;
  } body_byte_t;

  typedef struct packed {
    logic        data_valid;
    logic [7:0]  data_byte;
    cbd_status_e status;
    logic [31:0] consumed;
  } decoded_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] byte_value
  logic        s_axis_tuser;   // [0] start_of_body
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // [7:0] data_byte, [9:8] decode_status,
                               // [41:10] consumed_bytes, [47:42] zero
  logic        m_axis_tuser;   // [0] data_valid

  chunked_body_decoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // byte requests still to send, decoded results still to arrive
  body_byte_t pending_bytes[$];
  decoded_t   pending_results[$];
  logic [7:0] body_text[$];      // scratch body under construction
  body_byte_t next_byte;
  decoded_t   want;
  logic       byte_taken;
  int         src_idle_pct;
  int         snk_stall_pct;
  int         bytes_queued;
  int         mismatch_count;
  int         cycle_count;

  // predictor copy of the decoder state and the limit register
  body_phase_e          dec_phase;
  logic [CountBits-1:0] size_acc;
  logic                 digit_seen;
  logic [CountBits-1:0] remaining;
  logic [CountBits-1:0] body_len;
  logic [31:0]          consumed;
  cbd_status_e          dec_status;
  logic [31:0]          body_limit;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void restart_body();
    dec_phase  = PhSize;
    size_acc   = '0;
    digit_seen = 1'b0;
    remaining  = '0;
    body_len   = '0;
    consumed   = '0;
    dec_status = StBusy;
  endfunction

  // hex digit in either case, -1 for anything else
  function automatic int nibble_of(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b) - int'("0");
    if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
    if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
    return -1;
  endfunction

  // end of a size line: empty, last chunk, over the limit, or data follows
  function automatic void close_size_line();
    if (!digit_seen) begin
      dec_status = StBad;
    end else if (size_acc == '0) begin
      dec_phase = PhTrStart;
    end else if (64'(body_len) + 64'(size_acc) > 64'(body_limit)) begin
      // the sum is formed wide, so no wrap can hide an oversized chunk
      dec_status = StLarge;
    end else begin
      remaining = size_acc;
      dec_phase = PhData;
    end
  endfunction

  function automatic decoded_t decode_byte(input logic sob, input logic [7:0] b);
    decoded_t r;
    int       nib;
    r = '0;
    if (sob) restart_body();
    // once a final status is set, bytes are swallowed without counting
    if (dec_status == StBusy) begin
      if (consumed != '1) consumed = consumed + 1;
      case (dec_phase)
        PhSize: begin
          nib = nibble_of(b);
          if (nib >= 0) begin
            // one more digit would push the size past the counter width
            if (size_acc[CountBits-1 -: 4] != '0) begin
              dec_status = StBad;
            end else begin
              size_acc   = {size_acc[CountBits-5:0], 4'(nib)};
              digit_seen = 1'b1;
            end
          end else if (b == ChSemi) begin
            if (!digit_seen) dec_status = StBad;
            else dec_phase = PhExt;
          end else if (b == ChCr) begin
            dec_phase = PhSizeLf;
          end else begin
            dec_status = StBad;
          end
        end
        PhSizeLf: begin
          if (b == ChLf) close_size_line();
          else dec_status = StBad;
        end
        PhExt: begin
          if (b == ChCr) dec_phase = PhExtCr;
        end
        PhExtCr: begin
          if (b == ChLf) close_size_line();
          else if (b != ChCr) dec_phase = PhExt;
        end
        PhData: begin
          r.data_valid = 1'b1;
          r.data_byte  = b;
          remaining    = remaining - 1'b1;
          body_len     = body_len + 1'b1;
          if (remaining == '0) dec_phase = PhDataCr;
        end
        PhDataCr: begin
          if (b == ChCr) dec_phase = PhDataLf;
          else dec_status = StBad;
        end
        PhDataLf: begin
          if (b == ChLf) begin
            dec_phase  = PhSize;
            size_acc   = '0;
            digit_seen = 1'b0;
          end else begin
            dec_status = StBad;
          end
        end
        PhTrStart: begin
          if (b == ChCr) dec_phase = PhTrStartCr;
          else dec_phase = PhTrLine;
        end
        PhTrStartCr: begin
          // empty line ends the body
          if (b == ChLf) dec_status = StDone;
          else if (b == ChCr) dec_phase = PhTrLineCr;
          else dec_phase = PhTrLine;
        end
        PhTrLine: begin
          if (b == ChCr) dec_phase = PhTrLineCr;
        end
        PhTrLineCr: begin
          if (b == ChLf) dec_phase = PhTrStart;
          else if (b != ChCr) dec_phase = PhTrLine;
        end
        default: dec_status = StBad;
      endcase
    end
    r.status   = dec_status;
    r.consumed = consumed;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: byte requests and result ready, both changed at the falling edge
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
      // a held request only moves on once the decoder has taken it
      if (!s_axis_tvalid || byte_taken) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          next_byte = pending_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_byte.value;
          s_axis_tuser  <= next_byte.sob;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on each accepted byte, check each accepted result
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string what, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, got_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MaxCycles) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
    if (rst_ni) begin
      byte_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results.push_back(decode_byte(s_axis_tuser, s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                   $time, m_axis_tdata, m_axis_tuser);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("data_valid", 32'(want.data_valid), 32'(m_axis_tuser));
          check_field("data_byte", 32'(want.data_byte), 32'(m_axis_tdata[7:0]));
          check_field("decode_status", 32'(want.status), 32'(m_axis_tdata[9:8]));
          check_field("consumed_bytes", want.consumed, m_axis_tdata[41:10]);
          check_field("tdata padding", 32'd0, 32'(m_axis_tdata[47:42]));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void push_byte(input logic sob, input logic [7:0] b);
    body_byte_t item;
    item.sob   = sob;
    item.value = b;
    pending_bytes.push_back(item);
    bytes_queued++;
  endfunction

  // start flag goes on the first byte of the text only
  function automatic void push_text(input logic sob, input string s);
    for (int i = 0; i < s.len(); i++) push_byte(sob && i == 0, s[i]);
  endfunction

  // hex digits of a size, most significant first, letters in random case
  function automatic void put_hex(input logic [35:0] value, input int digits);
    logic [3:0] nib;
    for (int i = digits - 1; i >= 0; i--) begin
      nib = value[i*4 +: 4];
      if (nib < 4'd10) body_text.push_back(8'h30 + 8'(nib));
      else if ($urandom_range(1)) body_text.push_back(8'h41 + 8'(nib) - 8'd10);
      else body_text.push_back(8'h61 + 8'(nib) - 8'd10);
    end
  endfunction

  function automatic void put_crlf();
    body_text.push_back(ChCr);
    body_text.push_back(ChLf);
  endfunction

  // printable text with the odd bare cr or lf
  function automatic logic [7:0] text_byte();
    case ($urandom_range(9))
      0: return ChCr;
      1: return ChLf;
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  // bytes that upset the parser: line ends, separators, sign, prefix, non-hex
  function automatic logic [7:0] odd_byte();
    case ($urandom_range(7))
      0: return ChCr;
      1: return ChLf;
      2: return ChSemi;
      3: return "x";
      4: return " ";
      5: return "+";
      6: return "g";
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void put_extension();
    if ($urandom_range(3) == 0) begin
      body_text.push_back(ChSemi);
      repeat ($urandom_range(4)) body_text.push_back(text_byte());
    end
  endfunction

  // one random body: mostly well formed, some damaged, cut short or noise
  function automatic void add_body();
    int   chunks;
    int   sz;
    int   k;
    int   cut;
    int   r;
    logic start_flag;
    body_text.delete();
    chunks = $urandom_range(3);
    for (int c = 0; c < chunks; c++) begin
      r = $urandom_range(19);
      if (r == 0) begin
        // long size line: may overflow, exceed the limit or open a huge chunk
        put_hex({$urandom(), 4'($urandom_range(15))}, $urandom_range(7, 9));
        sz = 3;
      end else begin
        sz = (r < 4) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        put_hex(36'(sz), ((sz > 15) ? 2 : 1) + $urandom_range(2));
      end
      put_extension();
      put_crlf();
      repeat (sz) body_text.push_back(8'($urandom_range(255)));
      put_crlf();
    end
    // last chunk, trailer lines and the closing empty line
    put_hex(36'd0, $urandom_range(1, 2));
    put_extension();
    put_crlf();
    repeat ($urandom_range(2)) begin
      repeat ($urandom_range(5)) body_text.push_back(text_byte());
      put_crlf();
    end
    put_crlf();

    r = $urandom_range(99);
    if (r >= 92) begin
      body_text.delete();
      repeat ($urandom_range(1, 6)) body_text.push_back(odd_byte());
    end else if (r >= 76) begin
      // damage one byte, keep only a short tail since the rest is ignored
      k = $urandom_range(body_text.size() - 1);
      body_text[k] = odd_byte();
      cut = k + 1 + $urandom_range(2);
      while (body_text.size() > cut) body_text.delete(body_text.size() - 1);
    end else if (r >= 68) begin
      cut = $urandom_range(1, body_text.size() - 1);
      while (body_text.size() > cut) body_text.delete(body_text.size() - 1);
    end

    // a few bodies run on without a fresh start
    start_flag = ($urandom_range(19) != 0);
    foreach (body_text[i]) push_byte(start_flag && i == 0, body_text[i]);
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 2)) push_byte(1'b0, odd_byte());
    end
  endfunction

  // everything sent and answered, then the result register is left to drain
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || s_axis_tvalid || pending_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    body_limit = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic [31:0] limit;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    byte_taken    = 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    bytes_queued  = 0;
    mismatch_count = 0;
    cycle_count   = 0;
    body_limit    = 32'd1048576;
    restart_body();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed bodies at the reset limit; "\015\012" is cr lf
    // no start flag on the very first body, then a byte after completion
    push_text(1'b0, "0\015\012\015\012");
    push_text(1'b0, "Z");
    // both letter cases, overflow on the ninth digit
    push_text(1'b1, "aBcDeF001");
    // empty size before the extension, bare lf in the digits
    push_text(1'b1, ";");
    push_text(1'b1, "\012");
    // cr in the digits without lf
    push_text(1'b1, "1\015X");
    // extension holding a bare cr, extreme data bytes, clean end
    push_text(1'b1, "2;\015\015\012");
    push_byte(1'b0, 8'hFF);
    push_byte(1'b0, 8'h00);
    push_text(1'b0, "\015\0120\015\012\015\012");

    for (int p = 0; p < 8; p++) begin
      wait_drained();
      case (p)
        0: limit = 32'd3;
        1: limit = 32'hFFFF_FFFF;
        2: limit = 32'd0;
        3: limit = 32'd60;
        4: limit = 32'd1048576;
        5: limit = 32'd1;
        6: limit = 32'd25;
        default: limit = 32'hFFFF_FFFF;
      endcase
      write_limit(limit);
      // idling mix rotates: none, sender gaps, receiver stalls, both
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 68; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 68; end
        default: begin src_idle_pct = 16; snk_stall_pct = 16; end
      endcase
      // a chunk above a tiny limit
      if (p == 0) push_text(1'b1, "4\015\012");
      bytes_queued = 0;
      while (bytes_queued < 115) add_body();
    end

    wait_drained();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
